[hdl/klucb_pkg.sv]
// ----------------------------------------------------------------------------
// klucb_pkg
// Shared types, constants and constant log tables for the KL-UCB arm selector.
// ----------------------------------------------------------------------------
package klucb_pkg;

	localparam int Q_ONE      = 65536;
	localparam int GRID_STEPS = 100;
	localparam int LN2_Q16    = 45426;
	localparam int LN_W       = 23;
	localparam int KW         = 7;

	typedef logic signed [LN_W-1:0] ln_t;
	typedef ln_t ln_tab_t [GRID_STEPS];

	typedef struct packed {
		logic        start;
		logic        frac16;
		logic [31:0] x;
	} log_req_t;

	typedef struct packed {
		logic done;
		ln_t  res;
	} log_rsp_t;

	typedef struct packed {
		logic        start;
		logic [47:0] num;
		logic [31:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [16:0] quo;
	} div_rsp_t;

	typedef enum logic [1:0] {
		LG_IDLE,
		LG_NORM,
		LG_SQR,
		LG_SCALE
	} log_state_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_UPD_RD,
		ST_UPD_WR,
		ST_SCAN,
		ST_LT_GO,
		ST_LT_WAIT,
		ST_LL_GO,
		ST_LL_WAIT,
		ST_UB,
		ST_ARM_RD,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_LNP_GO,
		ST_LNP_WAIT,
		ST_LNO_GO,
		ST_LNO_WAIT,
		ST_G1,
		ST_G2,
		ST_G3,
		ST_TIE,
		ST_T_RD,
		ST_T_CHK,
		ST_OUT
	} sel_state_t;

	// elaboration-time ln, Q16.16 result, same steps as the log unit
	function automatic longint ln_const(logic [63:0] x, int frac);
		int          m;
		int          i;
		logic [63:0] y;
		longint      fp;
		longint      v;
		logic [63:0] mag;
		logic [63:0] r;
		if (x == 64'd0)
			return 0;
		m = 63;
		while (x[m] == 1'b0)
			m--;
		y = (m > 31) ? (x >> (m - 31)) : (x << (31 - m));
		fp = 0;
		for (i = 0; i < 16; i++) begin
			y = (y * y) >> 31;
			fp = fp << 1;
			if (y >= 64'h1_0000_0000) begin
				fp = fp | 1;
				y = y >> 1;
			end
		end
		v = longint'(m - frac) * 65536 + fp;
		mag = (v < 0) ? 64'(-v) : 64'(v);
		r = (mag * 64'(LN2_Q16)) >> 16;
		return (v < 0) ? -longint'(r) : longint'(r);
	endfunction

	function automatic ln_tab_t mk_ln_tab(bit one_minus);
		ln_tab_t t;
		longint  q;
		for (int k = 0; k < GRID_STEPS; k++) begin
			q = ((GRID_STEPS - k) * Q_ONE + 50) / GRID_STEPS;
			if (one_minus)
				q = Q_ONE - q;
			t[k] = ln_t'(ln_const(64'(q), 16));
		end
		return t;
	endfunction

	localparam ln_tab_t LN_Q_TAB   = mk_ln_tab(1'b0);
	localparam ln_tab_t LN_OMQ_TAB = mk_ln_tab(1'b1);

endpackage

[hdl/klucb_ram.sv]
// ----------------------------------------------------------------------------
// klucb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module klucb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[hdl/klucb_log.sv]
// ----------------------------------------------------------------------------
// klucb_log
// Iterative natural log, signed Q7.16 out: normalize one bit a cycle, then
// 16 squaring steps, then scale by ln 2.
// ----------------------------------------------------------------------------
module klucb_log import klucb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  log_req_t req,
	output log_rsp_t rsp
);

	log_state_t        state_q, state_d;
	logic [31:0]       y_q;
	logic signed [6:0] m_q;
	logic [15:0]       fp_q;
	logic [3:0]        cnt_q;
	logic              frac_q;
	logic              done_q;
	ln_t               res_q;

	logic [63:0]       sq;
	logic [32:0]       sqt;
	logic signed [6:0] mf;
	logic signed [22:0] v;
	logic [22:0]       mag;
	logic [38:0]       prod;
	logic [22:0]       r;
	ln_t               scaled;

	always_comb begin
		sq     = 64'(y_q) * 64'(y_q);
		sqt    = sq[63:31];
		mf     = m_q - (frac_q ? 7'sd16 : 7'sd0);
		v      = {mf, fp_q};
		mag    = v[22] ? 23'(-v) : 23'(v);
		prod   = 39'(mag) * 39'(LN2_Q16);
		r      = prod[38:16];
		scaled = v[22] ? -$signed(r) : $signed(r);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			LG_IDLE:  if (req.start && req.x != 32'd0) state_d = LG_NORM;
			LG_NORM:  if (y_q[31]) state_d = LG_SQR;
			LG_SQR:   if (cnt_q == 4'd15) state_d = LG_SCALE;
			LG_SCALE: state_d = LG_IDLE;
			default:  state_d = LG_IDLE;
		endcase
	end

	always_comb begin
		rsp.done = done_q;
		rsp.res  = res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LG_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == LG_SCALE) ||
				(state_q == LG_IDLE && req.start && req.x == 32'd0);
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			LG_IDLE: begin
				if (req.start) begin
					y_q    <= req.x;
					m_q    <= 7'sd31;
					fp_q   <= '0;
					cnt_q  <= '0;
					frac_q <= req.frac16;
					res_q  <= '0;
				end
			end
			LG_NORM: begin
				if (!y_q[31]) begin
					y_q <= {y_q[30:0], 1'b0};
					m_q <= m_q - 7'sd1;
				end
			end
			LG_SQR: begin
				fp_q  <= {fp_q[14:0], sqt[32]};
				y_q   <= sqt[32] ? sqt[32:1] : sqt[31:0];
				cnt_q <= cnt_q + 4'd1;
			end
			LG_SCALE: res_q <= scaled;
			default: ;
		endcase
	end

endmodule

[hdl/klucb_div.sv]
// ----------------------------------------------------------------------------
// klucb_div
// Restoring divider, 48-bit by 32-bit, one quotient bit a cycle; the
// quotient is clamped to 1.0 in Q1.16.
// ----------------------------------------------------------------------------
module klucb_div import klucb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [31:0] rem_q;
	logic [47:0] q_q;
	logic [31:0] den_q;

	logic [32:0] r2;
	logic        ge;

	always_comb begin
		r2 = {rem_q, q_q[47]};
		ge = r2 >= {1'b0, den_q};
		rsp.done = done_q;
		rsp.quo  = (q_q > 48'(Q_ONE)) ? 17'(Q_ONE) : q_q[16:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && cnt_q == 6'd47;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd47)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			q_q   <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= ge ? 32'(r2 - {1'b0, den_q}) : r2[31:0];
			q_q   <= {q_q[46:0], ge};
		end
	end

endmodule

[hdl/kl_ucb_arm_selector_top.sv]
// ----------------------------------------------------------------------------
// kl_ucb_arm_selector_top
// KL-UCB bandit arm selector: per-arm pull counts and reward sums in RAM,
// reward updates and arm selection by a fixed-point KL confidence bound.
// ----------------------------------------------------------------------------
// channel  dir  word                                     accepted
// s_       in   tuser: req_type; tdata: arm, reward, draw tvalid & tready
// m_       out  tuser: was_unexplored; tdata: chosen_arm  tvalid & tready
// cfg_     in   cfg_data: explore_gain                    cfg_valid & cfg_ready
//
// Update: stats RAM read, then write back.
// Select: scan of the valid bits; if every arm was pulled, the bound (two logs),
// then per arm the divider, two logs and the grid steps tried, then a
// tie-break sweep over the k RAM.
// Reset clears the valid bits; an unwritten arm reads as zero. One item at a
// time; a pending result stalls only the next select's completion.
// ----------------------------------------------------------------------------
module kl_ucb_arm_selector_top import klucb_pkg::*; #(
	parameter int NUM_ARMS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // arm_index[3:0], reward_value[20:4], random_draw[36:21]
	input  logic [0:0]  s_tuser,   // req_type[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // chosen_arm[3:0]
	output logic [0:0]  m_tuser,   // was_unexplored[0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [9:0]  cfg_data
);

	localparam int AW = $clog2(NUM_ARMS);
	localparam int LW = $clog2(NUM_ARMS + 1);

	sel_state_t state_q, state_d;

	logic [9:0]          gain_q;
	logic [31:0]         step_q;
	logic [NUM_ARMS-1:0] vld_q;
	logic [AW-1:0]       upd_arm_q;
	logic [16:0]         rew_q;
	logic [15:0]         draw_q;
	logic [AW-1:0]       idx_q;
	logic [31:0]         n_q;
	ln_t                 lt_q, lnln_q, lnp_q, lno_q;
	logic signed [31:0]  ub_q;
	logic [16:0]         p_q, omp_q;
	logic [KW-1:0]       k_q, best_q;
	logic signed [25:0]  t1_s1, t2_s1;
	logic                inf_s1, inf_s2;
	logic signed [59:0]  prod_s2;
	logic [LW-1:0]       len_q, pick_q, seen_q;
	logic [AW-1:0]       res_arm_q;
	logic                res_unexp_q;
	logic                m_tvalid_q;
	logic [3:0]          m_arm_q;
	logic                m_unexp_q;

	logic                st_we;
	logic [AW-1:0]       st_waddr, st_raddr;
	logic [79:0]         st_wdata, st_rd;
	logic                km_we;
	logic [KW-1:0]       km_wdata, km_rd;
	log_req_t            log_req;
	log_rsp_t            log_rsp;
	div_req_t            div_req;
	div_rsp_t            div_rsp;

	logic                accept;
	logic                arm_ok;
	logic                last;
	logic [AW-1:0]       idx_nxt;
	logic [31:0]         pulls_cur, pulls_new;
	logic [47:0]         sum_cur, sum_new;
	logic [48:0]         sum_ext;
	logic [16:0]         r_sat;
	logic [22:0]         ll_mag;
	logic [32:0]         ll_prod;
	logic signed [25:0]  ll_term;
	logic signed [31:0]  ub_c;
	ln_t                 lnq, lnomq;
	logic signed [23:0]  d1, d2;
	logic [23:0]         mag1, mag2;
	logic [40:0]         pr1, pr2;
	logic [24:0]         r1, r2;
	logic signed [25:0]  t1_c, t2_c;
	logic signed [26:0]  kl_c;
	logic signed [59:0]  prod_c, ub_ext;
	logic                pass, fin;
	logic [KW-1:0]       kfin;
	logic [16+LW-1:0]    pick_prod;
	logic                tie_hit, tie_match;

	assign accept    = s_tvalid && s_tready;
	assign arm_ok    = 32'(s_tdata[3:0]) < NUM_ARMS;
	assign last      = idx_q == AW'(NUM_ARMS - 1);
	assign idx_nxt   = last ? '0 : idx_q + AW'(1);
	assign cfg_ready = 1'b1;

	always_comb begin
		pulls_cur = vld_q[upd_arm_q] ? st_rd[31:0] : 32'd0;
		sum_cur   = vld_q[upd_arm_q] ? st_rd[79:32] : 48'd0;
		pulls_new = (pulls_cur == 32'hFFFF_FFFF) ? pulls_cur : pulls_cur + 32'd1;
		r_sat     = (rew_q > 17'(Q_ONE)) ? 17'(Q_ONE) : rew_q;
		sum_ext   = {1'b0, sum_cur} + 49'(r_sat);
		sum_new   = sum_ext[48] ? 48'hFFFF_FFFF_FFFF : sum_ext[47:0];

		ll_mag  = lnln_q[22] ? 23'(-lnln_q) : 23'(lnln_q);
		ll_prod = 33'(ll_mag) * 33'(gain_q);
		ll_term = lnln_q[22] ? -$signed({1'b0, ll_prod[32:8]})
			: $signed({1'b0, ll_prod[32:8]});
		ub_c    = 32'(lt_q) + 32'(ll_term);

		lnq   = LN_Q_TAB[k_q];
		lnomq = LN_OMQ_TAB[k_q];
		d1    = 24'(lnp_q) - 24'(lnq);
		d2    = 24'(lno_q) - 24'(lnomq);
		mag1  = d1[23] ? 24'(-d1) : 24'(d1);
		mag2  = d2[23] ? 24'(-d2) : 24'(d2);
		pr1   = 41'(mag1) * 41'(p_q);
		pr2   = 41'(mag2) * 41'(omp_q);
		r1    = pr1[40:16];
		r2    = pr2[40:16];
		t1_c  = (p_q == 17'd0) ? 26'sd0
			: (d1[23] ? -$signed({1'b0, r1}) : $signed({1'b0, r1}));
		t2_c  = (omp_q == 17'd0) ? 26'sd0
			: (d2[23] ? -$signed({1'b0, r2}) : $signed({1'b0, r2}));

		kl_c   = 27'(t1_s1) + 27'(t2_s1);
		prod_c = $signed({1'b0, n_q}) * kl_c;
		ub_ext = 60'(ub_q);
		pass   = !inf_s2 && (prod_s2 <= ub_ext);
		fin    = pass || k_q == KW'(GRID_STEPS - 1);
		kfin   = pass ? k_q : KW'(GRID_STEPS);

		pick_prod = (16+LW)'(draw_q) * (16+LW)'(len_q);
		tie_hit   = km_rd == best_q;
		tie_match = tie_hit && seen_q == pick_q;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (s_tuser[0])
						state_d = ST_SCAN;
					else if (arm_ok)
						state_d = ST_UPD_RD;
				end
			end
			ST_UPD_RD:   state_d = ST_UPD_WR;
			ST_UPD_WR:   state_d = ST_IDLE;
			ST_SCAN: begin
				if (!vld_q[idx_q])
					state_d = ST_OUT;
				else if (last)
					state_d = ST_LT_GO;
			end
			ST_LT_GO:    state_d = (step_q > 32'd1) ? ST_LT_WAIT : ST_LL_GO;
			ST_LT_WAIT:  if (log_rsp.done) state_d = ST_LL_GO;
			ST_LL_GO:    state_d = (lt_q > 0) ? ST_LL_WAIT : ST_UB;
			ST_LL_WAIT:  if (log_rsp.done) state_d = ST_UB;
			ST_UB:       state_d = ST_ARM_RD;
			ST_ARM_RD:   state_d = ST_DIV_GO;
			ST_DIV_GO:   state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: if (div_rsp.done) state_d = ST_LNP_GO;
			ST_LNP_GO:   state_d = (p_q != 17'd0) ? ST_LNP_WAIT : ST_LNO_GO;
			ST_LNP_WAIT: if (log_rsp.done) state_d = ST_LNO_GO;
			ST_LNO_GO:   state_d = (omp_q != 17'd0) ? ST_LNO_WAIT : ST_G1;
			ST_LNO_WAIT: if (log_rsp.done) state_d = ST_G1;
			ST_G1:       state_d = ST_G2;
			ST_G2:       state_d = ST_G3;
			ST_G3: begin
				if (!fin)
					state_d = ST_G1;
				else if (last)
					state_d = ST_TIE;
				else
					state_d = ST_ARM_RD;
			end
			ST_TIE:      state_d = ST_T_RD;
			ST_T_RD:     state_d = ST_T_CHK;
			ST_T_CHK:    state_d = tie_match ? ST_OUT : ST_T_RD;
			ST_OUT:      if (!m_tvalid_q || m_tready) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// outputs to RAMs and units
	always_comb begin
		s_tready    = state_q == ST_IDLE;
		st_we       = state_q == ST_UPD_WR;
		st_waddr    = upd_arm_q;
		st_wdata    = {sum_new, pulls_new};
		st_raddr    = (state_q == ST_UPD_RD) ? upd_arm_q : idx_q;
		km_we       = state_q == ST_G3 && fin;
		km_wdata    = kfin;
		div_req.start = state_q == ST_DIV_GO;
		div_req.num   = st_rd[79:32];
		div_req.den   = st_rd[31:0];
		log_req.frac16 = state_q != ST_LT_GO;
		unique case (state_q)
			ST_LT_GO: begin
				log_req.start = step_q > 32'd1;
				log_req.x     = step_q;
			end
			ST_LL_GO: begin
				log_req.start = lt_q > 0;
				log_req.x     = 32'(unsigned'(lt_q));
			end
			ST_LNP_GO: begin
				log_req.start = p_q != 17'd0;
				log_req.x     = 32'(p_q);
			end
			ST_LNO_GO: begin
				log_req.start = omp_q != 17'd0;
				log_req.x     = 32'(omp_q);
			end
			default: begin
				log_req.start = 1'b0;
				log_req.x     = 32'(p_q);
			end
		endcase
		m_tvalid = m_tvalid_q;
		m_tdata  = {4'd0, m_arm_q};
		m_tuser  = m_unexp_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			gain_q     <= '0;
			step_q     <= 32'd1;
			vld_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready)
				gain_q <= cfg_data;
			if (state_q == ST_UPD_WR) begin
				vld_q[upd_arm_q] <= 1'b1;
				if (step_q != 32'hFFFF_FFFF)
					step_q <= step_q + 32'd1;
			end
			if (state_q == ST_OUT && (!m_tvalid_q || m_tready))
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					upd_arm_q <= AW'(s_tdata[3:0]);
					rew_q     <= s_tdata[20:4];
					draw_q    <= s_tdata[36:21];
					idx_q     <= '0;
				end
			end
			ST_SCAN: begin
				if (!vld_q[idx_q]) begin
					res_arm_q   <= idx_q;
					res_unexp_q <= 1'b1;
				end else
					idx_q <= idx_nxt;
			end
			ST_LT_GO:    if (step_q <= 32'd1) lt_q <= '0;
			ST_LT_WAIT:  if (log_rsp.done) lt_q <= log_rsp.res;
			ST_LL_GO:    if (!(lt_q > 0)) lnln_q <= '0;
			ST_LL_WAIT:  if (log_rsp.done) lnln_q <= log_rsp.res;
			ST_UB: begin
				ub_q   <= ub_c;
				best_q <= KW'(GRID_STEPS);
				len_q  <= '0;
				idx_q  <= '0;
			end
			ST_ARM_RD:   k_q <= '0;
			ST_DIV_GO:   n_q <= st_rd[31:0];
			ST_DIV_WAIT: begin
				if (div_rsp.done) begin
					p_q   <= div_rsp.quo;
					omp_q <= 17'(Q_ONE) - div_rsp.quo;
				end
			end
			ST_LNP_GO:   if (p_q == 17'd0) lnp_q <= '0;
			ST_LNP_WAIT: if (log_rsp.done) lnp_q <= log_rsp.res;
			ST_LNO_GO:   if (omp_q == 17'd0) lno_q <= '0;
			ST_LNO_WAIT: if (log_rsp.done) lno_q <= log_rsp.res;
			ST_G1: begin
				t1_s1  <= t1_c;
				t2_s1  <= t2_c;
				inf_s1 <= omp_q != 17'd0 && k_q == '0;
			end
			ST_G2: begin
				prod_s2 <= prod_c;
				inf_s2  <= inf_s1;
			end
			ST_G3: begin
				if (fin) begin
					if (kfin < best_q) begin
						best_q <= kfin;
						len_q  <= LW'(1);
					end else if (kfin == best_q)
						len_q <= len_q + LW'(1);
					idx_q <= idx_nxt;
				end else
					k_q <= k_q + KW'(1);
			end
			ST_TIE: begin
				pick_q <= pick_prod[16+LW-1:16];
				seen_q <= '0;
				idx_q  <= '0;
			end
			ST_T_CHK: begin
				if (tie_match) begin
					res_arm_q   <= idx_q;
					res_unexp_q <= 1'b0;
				end else if (tie_hit)
					seen_q <= seen_q + LW'(1);
				idx_q <= idx_nxt;
			end
			ST_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					m_arm_q   <= 4'(res_arm_q);
					m_unexp_q <= res_unexp_q;
				end
			end
			default: ;
		endcase
	end

	klucb_ram #(.WIDTH(80), .DEPTH(NUM_ARMS)) u_stats_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.raddr (st_raddr),
		.rdata (st_rd)
	);

	klucb_ram #(.WIDTH(KW), .DEPTH(NUM_ARMS)) u_k_ram (
		.clk   (clk),
		.we    (km_we),
		.waddr (idx_q),
		.wdata (km_wdata),
		.raddr (idx_q),
		.rdata (km_rd)
	);

	klucb_log u_log (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (log_req),
		.rsp    (log_rsp)
	);

	klucb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

endmodule

[sim/tb_kl_ucb_arm_selector_top.sv]
// ----------------------------------------------------------------------------
// tb_kl_ucb_arm_selector_top
// Self-checking bench for the KL-UCB arm selector: reward updates and select
// requests go in on the input stream, a bit-exact fixed-point bandit predictor
// forecasts each chosen arm, and every output word is compared in order.
// ----------------------------------------------------------------------------
module tb_kl_ucb_arm_selector_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int  ARMS       = 16;
	localparam int  GRID       = 100;
	localparam bit  REQ_UPDATE = 1'b0;
	localparam bit  REQ_SELECT = 1'b1;
	localparam int  SETTLE     = 40;

	typedef struct {
		logic [3:0] arm;
		logic       unexplored;
	} pick_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic [0:0]  m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [9:0]  cfg_data = '0;

	// bandit state mirror
	int unsigned     step_t;
	int unsigned     pulls [ARMS];
	longint unsigned sums [ARMS];
	int unsigned     gain;

	pick_t pick_q [$];
	int    errors = 0;
	bit    no_idle = 1'b0;
	int    stall_left = 0;
	bit    m_hs = 1'b0;

	kl_ucb_arm_selector_top #(.NUM_ARMS(ARMS)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	initial begin
		#200_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic longint mul_trunc(longint a, longint unsigned b, int sh);
		longint unsigned mag;
		longint unsigned r;
		mag = (a < 0) ? longint'(-a) : longint'(a);
		r = (mag * b) >> sh;
		return (a < 0) ? -longint'(r) : longint'(r);
	endfunction

	// Q16.16 natural log via squaring log2
	function automatic longint fix_ln(longint unsigned x, int frac);
		int          msb;
		logic [63:0] y;
		longint      fbits;
		if (x == 0)
			return 0;
		msb = 63;
		while (x[msb] == 1'b0)
			msb--;
		y = (msb > 31) ? (x >> (msb - 31)) : (x << (31 - msb));
		fbits = 0;
		for (int i = 0; i < 16; i++) begin
			y = (y * y) >> 31;
			fbits = fbits << 1;
			if (y >= 64'h1_0000_0000) begin
				fbits = fbits | 1;
				y = y >> 1;
			end
		end
		return mul_trunc(longint'(msb - frac) * 65536 + fbits, 45426, 16);
	endfunction

	function automatic int bound_step(longint unsigned s, int unsigned n, longint ub);
		longint unsigned p;
		longint unsigned omp;
		longint unsigned q;
		longint          lnp;
		longint          lnomp;
		longint          kl;
		bit              infinite;
		p = s / n;
		if (p > 65536)
			p = 65536;
		omp = 65536 - p;
		lnp = p ? fix_ln(p, 16) : 0;
		lnomp = omp ? fix_ln(omp, 16) : 0;
		for (int k = 0; k < GRID; k++) begin
			q = ((GRID - k) * 64'd65536 + 50) / GRID;
			kl = 0;
			infinite = 1'b0;
			if (p != 0)
				kl += mul_trunc(lnp - fix_ln(q, 16), p, 16);
			if (omp != 0) begin
				if (q == 65536)
					infinite = 1'b1;
				else
					kl += mul_trunc(lnomp - fix_ln(65536 - q, 16), omp, 16);
			end
			if (!infinite && longint'(n) * kl <= ub)
				return k;
		end
		return GRID;
	endfunction

	task automatic predict_select(logic [15:0] draw);
		int     kv [ARMS];
		int     best;
		int     cnt;
		int     pick;
		int     seen;
		longint lt;
		longint ub;
		pick_t  e;
		for (int i = 0; i < ARMS; i++) begin
			if (pulls[i] == 0) begin
				e.arm = 4'(i);
				e.unexplored = 1'b1;
				pick_q = {pick_q, e};
				return;
			end
		end
		lt = (step_t > 1) ? fix_ln(step_t, 0) : 0;
		ub = lt;
		if (lt > 0)
			ub += mul_trunc(fix_ln(lt, 16), gain, 8);
		best = GRID;
		for (int i = 0; i < ARMS; i++) begin
			kv[i] = bound_step(sums[i], pulls[i], ub);
			if (kv[i] < best)
				best = kv[i];
		end
		cnt = 0;
		for (int i = 0; i < ARMS; i++)
			if (kv[i] == best)
				cnt++;
		pick = int'((longint'(draw) * cnt) >> 16);
		seen = 0;
		e.arm = 0;
		e.unexplored = 1'b0;
		for (int i = 0; i < ARMS; i++) begin
			if (kv[i] == best) begin
				if (seen == pick) begin
					e.arm = 4'(i);
					break;
				end
				seen++;
			end
		end
		pick_q = {pick_q, e};
	endtask

	task automatic apply_update(int arm, int unsigned reward);
		if (arm >= ARMS)
			return;
		if (reward > 65536)
			reward = 65536;
		if (step_t != 32'hFFFF_FFFF)
			step_t++;
		if (pulls[arm] != 32'hFFFF_FFFF)
			pulls[arm]++;
		sums[arm] += reward;
		if (sums[arm] > 48'hFFFF_FFFF_FFFF)
			sums[arm] = 48'hFFFF_FFFF_FFFF;
	endtask

	task automatic send_word(bit req, int arm, int unsigned reward, int unsigned draw);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= {3'b0, draw[15:0], reward[16:0], arm[3:0]};
		do
			@(negedge clk);
		while (!s_tready);
		@(posedge clk);
		if (req == REQ_SELECT)
			predict_select(draw[15:0]);
		else
			apply_update(arm, reward);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pick_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_gain(int unsigned value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= value[9:0];
		do
			@(negedge clk);
		while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
		gain = value & 10'h3FF;
	endtask

	// result side: stall draws, compare at negedge, handshake at next posedge
	always @(negedge clk) begin
		pick_t e;
		m_hs = m_tvalid && m_tready;
		if (m_hs) begin
			if (pick_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected word: arm %0d unexplored %0d", m_tdata[3:0], m_tuser[0]);
			end else begin
				e = pick_q.pop_front();
				if (e.arm !== m_tdata[3:0] || e.unexplored !== m_tuser[0]) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp arm %0d unexp %0d, got arm %0d unexp %0d",
							e.arm, e.unexplored, m_tdata[3:0], m_tuser[0]);
				end
			end
		end
	end

	always @(posedge clk) begin
		bit rdy;
		if (m_hs)
			stall_left = no_idle ? 0 : $urandom_range(0, 9);
		if (stall_left > 0) begin
			stall_left--;
			rdy = 1'b0;
		end else
			rdy = 1'b1;
		m_tready <= rdy;
	end

	task automatic test_unexplored();
		send_word(REQ_SELECT, 0, 0, 16'hFFFF);
		send_word(REQ_UPDATE, 0, 17'h1FFFF, 0);
		send_word(REQ_SELECT, 5, 0, 0);
		send_word(REQ_UPDATE, 1, 0, 0);
		send_word(REQ_UPDATE, 1, 0, 0);
		send_word(REQ_SELECT, 0, 0, 16'h8000);
		for (int a = 2; a < ARMS; a++)
			send_word(REQ_UPDATE, a, (a == ARMS - 1) ? 65536 : a * 4000, 0);
	endtask

	task automatic test_ties();
		send_word(REQ_SELECT, 0, 0, 0);
		send_word(REQ_SELECT, 0, 0, 16'hFFFF);
		send_word(REQ_SELECT, 15, 17'h10000, 16'h5555);
		send_word(REQ_UPDATE, 15, 17'h10000, 0);
		send_word(REQ_SELECT, 0, 0, 16'hFFFF);
	endtask

	task automatic test_gain(int unsigned value, int n);
		write_gain(value);
		for (int i = 0; i < n; i++)
			send_word(REQ_SELECT, $urandom_range(0, 15), $urandom_range(0, 131071),
				$urandom_range(0, 65535));
	endtask

	task automatic test_random(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 70)
				send_word(REQ_UPDATE, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15),
					$urandom_range(0, 131071), $urandom_range(0, 65535));
			else
				send_word(REQ_SELECT, $urandom_range(0, 15), $urandom_range(0, 131071),
					$urandom_range(0, 65535));
		end
	endtask

	task automatic test_pressure();
		drain();
		no_idle = 1'b1;
		test_random(30);
		no_idle = 1'b0;
	endtask

	initial begin
		step_t = 1;
		gain = 0;
		for (int i = 0; i < ARMS; i++) begin
			pulls[i] = 0;
			sums[i] = 0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_unexplored();
		test_ties();
		test_gain(1023, 3);
		test_random(90);
		test_gain(0, 3);
		test_pressure();
		test_gain(300, 2);
		test_random(150);
		drain();
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
